/* rtl/amp_pkg.sv */
// Package for the argmax pooling block: constants, types and binary32 compare helpers.
package amp_pkg;

	localparam int WINDOW_MAX = 9;
	localparam int IDX_W      = 4;
	localparam int WS_W       = 4;
	localparam int FP_W       = 32;
	localparam int LEAVES     = 16;
	localparam int LEVELS     = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [WS_W-1:0] WS_RESET   = 4'd9;
	localparam logic [FP_W-1:0] CMIN_RESET = 32'hFF80_0000;
	localparam logic [FP_W-1:0] CMAX_RESET = 32'h7F80_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_CLAMP_MIN   = 2'd1,
		REG_CLAMP_MAX   = 2'd2
	} cfg_reg_t;

	typedef logic [WINDOW_MAX-1:0][FP_W-1:0] window_t;

	typedef struct packed {
		logic [FP_W-1:0]  key;
		logic [IDX_W-1:0] idx;
	} cand_t;

	function automatic logic is_nan(input logic [FP_W-1:0] x);
		return (x[FP_W-2:0] > 31'h7F80_0000);
	endfunction

	// Unsigned key that orders like the value; +0 and -0 share one key
	function automatic logic [FP_W-1:0] order_key(input logic [FP_W-1:0] x);
		if (x[FP_W-2:0] == '0) return 32'h8000_0000;
		return x[FP_W-1] ? ~x : (x | 32'h8000_0000);
	endfunction

	// Ordered a > b: false when either side is NaN
	function automatic logic fgt(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
		if (is_nan(a) || is_nan(b)) return 1'b0;
		return order_key(a) > order_key(b);
	endfunction

endpackage

/* rtl/amp_ifs.sv */
// Stream interfaces for window requests, results and configuration writes.
interface amp_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [amp_pkg::FP_W-1:0]             elem0, elem1, elem2, elem3, elem4;
	logic [amp_pkg::FP_W-1:0]             elem5, elem6, elem7, elem8;
	modport source (output valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7,
		elem8, input ready);
	modport sink (input valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7,
		elem8, output ready);
endinterface

interface amp_result_if;
	logic                      valid;
	logic                      ready;
	logic [amp_pkg::FP_W-1:0]  pooled_value;
	logic [amp_pkg::IDX_W-1:0] winner_index;
	modport source (output valid, pooled_value, winner_index, input ready);
	modport sink (input valid, pooled_value, winner_index, output ready);
endinterface

interface amp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [amp_pkg::CFG_IDX_W-1:0] index;
	logic [amp_pkg::FP_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/amp_argmax.sv */
// Argmax stage: key tree over the window, registered winner value and index.
module amp_argmax (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  amp_pkg::window_t           elem_s1,
	input  logic [amp_pkg::WS_W-1:0]   window_size,
	input  logic                       ready_next,
	output logic                       ready_s2,
	output logic                       valid_s2,
	output logic [amp_pkg::FP_W-1:0]   value_s2,
	output logic [amp_pkg::IDX_W-1:0]  idx_s2
);
	import amp_pkg::*;

	cand_t lvl [0:LEVELS][0:LEAVES-1];
	cand_t best;

	// Build leaf keys and reduce pairwise; the right side wins only when strictly greater
	always_comb begin
		for (int l = 0; l <= LEVELS; l++) begin
			for (int j = 0; j < LEAVES; j++) begin
				lvl[l][j] = '0;
			end
		end
		for (int k = 0; k < WINDOW_MAX; k++) begin
			lvl[0][k].idx = IDX_W'(k);
			if (k == 0) begin
				lvl[0][k].key = is_nan(elem_s1[0]) ? '1 : order_key(elem_s1[0]);
			end else if ((IDX_W'(k) < window_size) && !is_nan(elem_s1[k])) begin
				lvl[0][k].key = order_key(elem_s1[k]);
			end
		end
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j < LEAVES / 2; j++) begin
				if (lvl[l][2*j+1].key > lvl[l][2*j].key) lvl[l+1][j] = lvl[l][2*j+1];
				else lvl[l+1][j] = lvl[l][2*j];
			end
		end
		best = lvl[LEVELS][0];
	end

	assign ready_s2 = !valid_s2 || ready_next;

	// Advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (ready_s2) valid_s2 <= valid_s1;
	end

	// Capture the winner
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			value_s2 <= elem_s1[best.idx];
			idx_s2   <= best.idx;
		end
	end
endmodule

/* rtl/amp_clamp.sv */
// Clamp stage: bound the winner by clamp_max then clamp_min, hold the result register.
module amp_clamp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s2,
	input  logic [amp_pkg::FP_W-1:0]   value_s2,
	input  logic [amp_pkg::IDX_W-1:0]  idx_s2,
	input  logic [amp_pkg::FP_W-1:0]   clamp_min,
	input  logic [amp_pkg::FP_W-1:0]   clamp_max,
	input  logic                       ready_next,
	output logic                       ready_s3,
	output logic                       valid_s3,
	output logic [amp_pkg::FP_W-1:0]   value_s3,
	output logic [amp_pkg::IDX_W-1:0]  idx_s3
);
	import amp_pkg::*;

	logic [FP_W-1:0] upper;
	logic [FP_W-1:0] bounded;

	// Apply the upper bound, then the lower bound
	always_comb begin
		upper   = fgt(clamp_max, value_s2) ? value_s2 : clamp_max;
		bounded = fgt(upper, clamp_min) ? upper : clamp_min;
	end

	assign ready_s3 = !valid_s3 || ready_next;

	// Advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (ready_s3) valid_s3 <= valid_s2;
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			value_s3 <= bounded;
			idx_s3   <= idx_s2;
		end
	end
endmodule

/* rtl/argmax_pool_window9_clamp.sv */
// Top level of the argmax pooling block with output clamping.
// A request passes the input, argmax and clamp registers in turn to become its result.
// One request per cycle unless results stall; each stage advances when the next one is free.
// A stalled result holds only the stages behind it that are full.
// Reset: arst_n clears all stage valids; window_size = 9, clamp_min = -inf, clamp_max = +inf.
module argmax_pool_window9_clamp (
	input  logic          clk,
	input  logic          arst_n,
	amp_item_if.sink      items,
	amp_result_if.source  results,
	amp_cfg_if.sink       cfg
);
	import amp_pkg::*;

	logic [WS_W-1:0] window_size_q;
	logic [FP_W-1:0] clamp_min_q;
	logic [FP_W-1:0] clamp_max_q;

	logic             valid_s1;
	window_t          elem_s1;
	logic             ready_s1;
	logic             ready_s2;
	logic             valid_s2;
	logic [FP_W-1:0]  value_s2;
	logic [IDX_W-1:0] idx_s2;
	logic             ready_s3;
	logic             valid_s3;

	// Take configuration writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
			clamp_min_q   <= CMIN_RESET;
			clamp_max_q   <= CMAX_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW_SIZE: window_size_q <= cfg.data[WS_W-1:0];
				REG_CLAMP_MIN:   clamp_min_q   <= cfg.data;
				REG_CLAMP_MAX:   clamp_max_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register stage
	assign ready_s1    = !valid_s1 || ready_s2;
	assign items.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (ready_s1) valid_s1 <= items.valid;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && items.valid) begin
			elem_s1 <= {items.elem8, items.elem7, items.elem6, items.elem5, items.elem4,
				items.elem3, items.elem2, items.elem1, items.elem0};
		end
	end

	amp_argmax u_argmax (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.elem_s1     (elem_s1),
		.window_size (window_size_q),
		.ready_next  (ready_s3),
		.ready_s2    (ready_s2),
		.valid_s2    (valid_s2),
		.value_s2    (value_s2),
		.idx_s2      (idx_s2)
	);

	amp_clamp u_clamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.value_s2   (value_s2),
		.idx_s2     (idx_s2),
		.clamp_min  (clamp_min_q),
		.clamp_max  (clamp_max_q),
		.ready_next (results.ready),
		.ready_s3   (ready_s3),
		.valid_s3   (valid_s3),
		.value_s3   (results.pooled_value),
		.idx_s3     (results.winner_index)
	);

	assign results.valid = valid_s3;

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 < IDX_W'(WINDOW_MAX)))
		else $error("winner index beyond window");

	a_small_window: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (window_size_q <= WS_W'(1))) |-> (idx_s2 == '0))
		else $error("winner outside a one element window");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && !results.ready) |-> !items.ready)
		else $error("request taken while pipeline is full and stalled");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> valid_s1)
		else $error("accepted request lost at input stage");
`endif
endmodule
